/* src/ple_pkg.sv */
// ----------------------------------------------------------------------------
// ple_pkg
// Shared types and constants for the positional list engine.
// ----------------------------------------------------------------------------
package ple_pkg;

	localparam int VAL_W = 32;   // element value width
	localparam int POS_W = 6;    // position field width
	localparam int CMP_W = 7;    // position/count compare width (holds 64)
	localparam int MODE_W = 3;
	localparam int STAT_W = 2;

	// input mode codes
	localparam logic [MODE_W-1:0] MODE_LIST      = 3'd0;
	localparam logic [MODE_W-1:0] MODE_INS_FRONT = 3'd1;
	localparam logic [MODE_W-1:0] MODE_INS_POS   = 3'd2;
	localparam logic [MODE_W-1:0] MODE_APPEND    = 3'd3;
	localparam logic [MODE_W-1:0] MODE_DELETE    = 3'd4;

	// result status codes
	localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
	localparam logic [STAT_W-1:0] STAT_RANGE = 2'd1;
	localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;
	localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd3;

	typedef enum logic [2:0] {
		OP_LIST,
		OP_INS_FRONT,
		OP_INS_POS,
		OP_APPEND,
		OP_DELETE
	} op_t;

	typedef struct packed {
		op_t                     op;
		logic signed [VAL_W-1:0] value;
		logic [POS_W-1:0]        position;
	} cmd_t;

	typedef struct packed {
		logic signed [VAL_W-1:0] element;
		logic [POS_W-1:0]        element_position;
		logic [STAT_W-1:0]       status;
		logic                    last;
	} res_t;

endpackage

/* src/ple_front.sv */
// ----------------------------------------------------------------------------
// ple_front
// Input side: takes command beats, decodes the mode, drops unused modes.
// ----------------------------------------------------------------------------
module ple_front import ple_pkg::*; (
	input  logic               s_axis_tvalid,
	output logic               s_axis_tready,
	input  logic [39:0]        s_axis_tdata,
	input  logic [MODE_W-1:0]  s_axis_tuser,
	output logic               push_valid,
	input  logic               push_ready,
	output cmd_t               push_cmd
);

	logic mode_ok;

	always_comb begin
		mode_ok      = 1'b1;
		push_cmd.op  = OP_LIST;
		case (s_axis_tuser)
			MODE_LIST:      push_cmd.op = OP_LIST;
			MODE_INS_FRONT: push_cmd.op = OP_INS_FRONT;
			MODE_INS_POS:   push_cmd.op = OP_INS_POS;
			MODE_APPEND:    push_cmd.op = OP_APPEND;
			MODE_DELETE:    push_cmd.op = OP_DELETE;
			default:        mode_ok     = 1'b0;   // unused modes: no result
		endcase
		push_cmd.value    = s_axis_tdata[VAL_W-1:0];
		push_cmd.position = s_axis_tdata[VAL_W+POS_W-1:VAL_W];
	end

	assign s_axis_tready = push_ready;
	assign push_valid    = s_axis_tvalid && mode_ok;

endmodule

/* src/ple_cmd_fifo.sv */
// ----------------------------------------------------------------------------
// ple_cmd_fifo
// Two-entry command queue between the front and back ends.
// ----------------------------------------------------------------------------
module ple_cmd_fifo import ple_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push_valid,
	output logic push_ready,
	input  cmd_t push_cmd,
	output logic pop_valid,
	input  logic pop,
	output cmd_t pop_cmd
);

	cmd_t       mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] fill_q;
	logic       do_push;
	logic       do_pop;

	assign push_ready = (fill_q != 2'd2);
	assign pop_valid  = (fill_q != 2'd0);
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && pop_valid;
	assign pop_cmd    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({do_push, do_pop})
				2'b10:   fill_q <= fill_q + 2'd1;
				2'b01:   fill_q <= fill_q - 2'd1;
				default: fill_q <= fill_q;
			endcase
		end
	end

endmodule

/* src/ple_back.sv */
// ----------------------------------------------------------------------------
// ple_back
// Execution side: shifting cell array, element count, result register.
// ----------------------------------------------------------------------------
module ple_back import ple_pkg::*; #(
	parameter int CAPACITY = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cmd_valid,
	input  cmd_t        cmd,
	output logic        cmd_pop,
	output logic        res_valid,
	input  logic        res_ready,
	output res_t        res
);

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int IW = $clog2(CAPACITY);

	typedef enum logic {ST_IDLE, ST_LIST} state_t;

	state_t                  state_q;
	logic [CW-1:0]           count_q;
	logic [IW-1:0]           idx_q;
	logic                    out_valid_q;
	res_t                    out_res_q;
	logic signed [VAL_W-1:0] cell_q [CAPACITY];
	logic signed [VAL_W-1:0] cell_d [CAPACITY];

	logic              take;
	logic              cmd_fire;
	logic              do_ins;
	logic              do_del;
	logic              do_rot;
	logic              full;
	logic [CMP_W-1:0]  cnt_x;
	logic [CMP_W-1:0]  pos_x;
	logic [CMP_W-1:0]  at_x;
	logic [CMP_W-1:0]  end_x;
	logic [STAT_W-1:0] cmd_stat;
	logic              list_last;

	assign take     = !out_valid_q || res_ready;
	assign cmd_fire = (state_q == ST_IDLE) && cmd_valid && take;
	assign cmd_pop  = cmd_fire;
	assign cnt_x    = CMP_W'(count_q);
	assign pos_x    = CMP_W'(cmd.position);
	assign end_x    = cnt_x - CMP_W'(1);
	assign full     = (count_q == CW'(CAPACITY));
	assign list_last = ((CMP_W'(idx_q) + CMP_W'(1)) == cnt_x);

	// status and target position of the command at the queue head
	always_comb begin
		cmd_stat = STAT_OK;
		at_x     = pos_x;
		case (cmd.op)
			OP_LIST: begin
				if (count_q == '0) cmd_stat = STAT_EMPTY;
			end
			OP_INS_FRONT: begin
				at_x = '0;
				if (full) cmd_stat = STAT_FULL;
			end
			OP_INS_POS: begin
				if (full) cmd_stat = STAT_FULL;
				else if (pos_x > cnt_x) cmd_stat = STAT_RANGE;
			end
			OP_APPEND: begin
				at_x = cnt_x;
				if (full) cmd_stat = STAT_FULL;
			end
			OP_DELETE: begin
				if (count_q == '0) cmd_stat = STAT_EMPTY;
				else if (pos_x >= cnt_x) cmd_stat = STAT_RANGE;
			end
			default: cmd_stat = STAT_OK;
		endcase
	end

	assign do_ins = cmd_fire && (cmd_stat == STAT_OK) &&
		(cmd.op == OP_INS_FRONT || cmd.op == OP_INS_POS || cmd.op == OP_APPEND);
	assign do_del = cmd_fire && (cmd_stat == STAT_OK) && (cmd.op == OP_DELETE);
	// listing rotates the occupied window left; after count steps it is restored
	assign do_rot = (state_q == ST_LIST) && take;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic signed [VAL_W-1:0] prev_v;
		logic signed [VAL_W-1:0] next_v;
		if (i == 0) begin : g_first
			assign prev_v = cmd.value;
		end else begin : g_prev
			assign prev_v = cell_q[i-1];
		end
		if (i == CAPACITY - 1) begin : g_lastc
			assign next_v = cell_q[i];
		end else begin : g_next
			assign next_v = cell_q[i+1];
		end
		always_comb begin
			cell_d[i] = cell_q[i];
			if (do_ins) begin
				if (CMP_W'(i) > at_x) cell_d[i] = prev_v;
				else if (CMP_W'(i) == at_x) cell_d[i] = cmd.value;
			end else if (do_del) begin
				if (CMP_W'(i) >= at_x) cell_d[i] = next_v;
			end else if (do_rot) begin
				if (CMP_W'(i) == end_x) cell_d[i] = cell_q[0];
				else if (CMP_W'(i) < end_x) cell_d[i] = next_v;
			end
		end
	end

	always_ff @(posedge clk) begin
		cell_q <= cell_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
			out_res_q   <= '0;
		end else begin
			if (do_ins) count_q <= count_q + CW'(1);
			if (do_del) count_q <= count_q - CW'(1);
			case (state_q)
				ST_IDLE: begin
					if (cmd_fire) begin
						if (cmd.op == OP_LIST && cmd_stat == STAT_OK) begin
							state_q     <= ST_LIST;
							idx_q       <= '0;
							out_valid_q <= out_valid_q && !res_ready;
						end else begin
							out_valid_q                <= 1'b1;
							out_res_q.element          <= '0;
							out_res_q.element_position <= '0;
							out_res_q.status           <= cmd_stat;
							out_res_q.last             <= 1'b1;
						end
					end else if (res_ready) begin
						out_valid_q <= 1'b0;
					end
				end
				ST_LIST: begin
					if (take) begin
						out_valid_q                <= 1'b1;
						out_res_q.element          <= cell_q[0];
						out_res_q.element_position <= POS_W'(idx_q);
						out_res_q.status           <= STAT_OK;
						out_res_q.last             <= list_last;
						idx_q                      <= idx_q + IW'(1);
						if (list_last) state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign res_valid = out_valid_q;
	assign res       = out_res_q;

endmodule

/* src/positional_list_engine_top.sv */
// ----------------------------------------------------------------------------
// positional_list_engine_top
// Ordered list of up to CAPACITY signed 32-bit values with positional
// insert, append, delete and full listing.
// ----------------------------------------------------------------------------
//
//  Channel   Dir  Beat contents
//  s_axis    in   tdata: value[31:0], position[37:32]; tuser: mode[2:0]
//  m_axis    out  tdata: element[31:0], element_position[37:32];
//                 tuser: status[1:0]; tlast: last result of the command
//
//  Insert/append/delete: the command passes through the command queue,
//  is executed and its result is registered. Listing: the command is
//  taken, then one beat per stored element follows, one per cycle while
//  m_axis does not stall; the cell array rotates one place per beat.
//  Reset clears the element count and all control; cell contents are kept
//  but never read before written. The input side keeps accepting into the
//  two-entry queue while results wait on m_axis; the output register holds
//  a result until tready, and the execution stage stalls behind it.
//  Modes 5 to 7 are accepted and dropped without a result.
// ----------------------------------------------------------------------------
module positional_list_engine_top import ple_pkg::*; #(
	parameter int CAPACITY = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_axis_tvalid,
	output logic              s_axis_tready,
	input  logic [39:0]       s_axis_tdata,   // value[31:0], position[37:32], pad
	input  logic [MODE_W-1:0] s_axis_tuser,   // mode[2:0]
	output logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	output logic [39:0]       m_axis_tdata,   // element[31:0], element_position[37:32], pad
	output logic [STAT_W-1:0] m_axis_tuser,   // status[1:0]
	output logic              m_axis_tlast
);

	logic push_valid;
	logic push_ready;
	cmd_t push_cmd;
	logic cmd_valid;
	logic cmd_pop;
	cmd_t cmd;
	res_t res;

	// front end: decode mode, drop unused codes
	ple_front u_front (
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.push_valid    (push_valid),
		.push_ready    (push_ready),
		.push_cmd      (push_cmd)
	);

	// decoupling queue between front and back
	ple_cmd_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_cmd   (push_cmd),
		.pop_valid  (cmd_valid),
		.pop        (cmd_pop),
		.pop_cmd    (cmd)
	);

	// back end: cell array, count, result register
	ple_back #(
		.CAPACITY (CAPACITY)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop),
		.res_valid (m_axis_tvalid),
		.res_ready (m_axis_tready),
		.res       (res)
	);

	assign m_axis_tdata = {2'b00, res.element_position, res.element};
	assign m_axis_tuser = res.status;
	assign m_axis_tlast = res.last;

endmodule
